/* hdl/assert_macros.svh */
// Assertion macros used by the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pcc_pkg.sv */
// Constants, types and the arctangent table of the polar/cartesian converter
`timescale 1ns / 1ps

package pcc_pkg;

   localparam int ITERATIONS = 16;
   localparam int DATA_WIDTH = 16;
   localparam int TABLE_SIZE = 24;
   localparam int N_ITER     = (ITERATIONS > TABLE_SIZE) ? TABLE_SIZE : ITERATIONS;
   localparam int CLIP_W_RAW = (DATA_WIDTH > 16) ? 16 : DATA_WIDTH;
   localparam int CLIP_W     = (CLIP_W_RAW < 2) ? 2 : CLIP_W_RAW;

   // x/y carry 16 fraction bits, angles 20 fraction bits
   localparam int XY_W   = 28;
   localparam int Z_W    = 24;
   localparam int GAIN_W = 17;
   localparam int PROD_W = XY_W + GAIN_W;
   localparam int RND_W  = PROD_W + 1 - 24;
   localparam int IDX_W  = 5;

   localparam logic signed [GAIN_W-1:0] GAIN_Q16   = 17'sd39797;
   localparam logic signed [Z_W-1:0]    HALF_PI_Z  = 24'sd1647099;
   localparam logic signed [16:0]       PI_Q12     = 17'sd12868;
   localparam logic signed [16:0]       TWO_PI_Q12 = 17'sd25736;
   localparam logic signed [RND_W-1:0]  RADIUS_MAX = RND_W'(46341);
   localparam logic signed [RND_W-1:0]  CLIP_HI    = RND_W'((64'sd1 <<< (CLIP_W - 1)) - 1);
   localparam logic signed [RND_W-1:0]  CLIP_LO    = -RND_W'(64'sd1 <<< (CLIP_W - 1));

   typedef enum logic {
      CMD_CART_TO_POL = 1'b0,
      CMD_POL_TO_CART = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic                     origin;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
   } stage_type;

   // round(atan(2^-i) * 2^20)
   function automatic logic signed [Z_W-1:0] atan_z(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 24'sd823550;
         5'd1:    v = 24'sd486170;
         5'd2:    v = 24'sd256879;
         5'd3:    v = 24'sd130396;
         5'd4:    v = 24'sd65451;
         5'd5:    v = 24'sd32757;
         5'd6:    v = 24'sd16383;
         5'd7:    v = 24'sd8192;
         5'd8:    v = 24'sd4096;
         5'd9:    v = 24'sd2048;
         5'd10:   v = 24'sd1024;
         5'd11:   v = 24'sd512;
         5'd12:   v = 24'sd256;
         5'd13:   v = 24'sd128;
         5'd14:   v = 24'sd64;
         5'd15:   v = 24'sd32;
         5'd16:   v = 24'sd16;
         5'd17:   v = 24'sd8;
         5'd18:   v = 24'sd4;
         5'd19:   v = 24'sd2;
         5'd20:   v = 24'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/polar_cartesian_converter_unit.sv */
// Polar/cartesian converter: quadrant fold, CORDIC stages, gain multiply, rounding
//
// Input channel req_*: one coordinate pair per beat. req_tuser is the command
// (0 = cartesian to polar, 1 = polar to cartesian). req_tdata holds
// first_value (x or radius, Q7.8) in [15:0] and second_value (y in Q7.8 or
// angle in Q3.12 radians) in [31:16].
// Result channel rsp_*: one beat per input beat, in order. rsp_tdata holds
// first_result (radius or x, 17 bits signed) in [16:0] and second_result
// (angle or y, 16 bits signed) in [32:17]; rsp_tuser is the saturated flag.
// Pipeline: one fold stage, one register per CORDIC iteration, one
// gain-multiply stage and the output register.
// Throughput: one beat per cycle while the pipeline is not held (see
// below); every stage holds one item.
// When rsp_tready is low with a valid result, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated. A free output register
// lets the pipeline advance regardless of rsp_tready.
// Reset clears all valid bits; the block takes beats the cycle after.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module polar_cartesian_converter_unit
   import pcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] first_value, [31:16] second_value
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] first_result, [32:17] second_result, zero fill
   output logic        rsp_tuser    // [0] saturated
);

   logic                      adv;
   logic                      vld_ff [0:N_ITER];
   stage_type                 stg_ff [0:N_ITER];
   stage_type                 stg_in [0:N_ITER];

   logic                      mul_vld_ff;
   cmd_type                   mul_cmd_ff;
   logic                      mul_origin_ff;
   logic signed [Z_W-1:0]     mul_z_ff;
   logic signed [PROD_W-1:0]  mul_px_ff, mul_px_in;
   logic signed [PROD_W-1:0]  mul_py_ff, mul_py_in;

   logic                      out_vld_ff;
   cmd_type                   out_cmd_ff;
   logic signed [16:0]        out_first_ff, out_first_in;
   logic signed [15:0]        out_second_ff, out_second_in;
   logic                      out_sat_ff, out_sat_in;

   // advance everything unless a result sits unaccepted
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // fold into the convergence range of the iterations
   always_comb begin
      logic signed [15:0]     a;
      logic signed [15:0]     b;
      logic signed [16:0]     bw;
      logic signed [XY_W-1:0] xa;
      logic signed [XY_W-1:0] yb;
      logic signed [Z_W-1:0]  zb;
      a  = signed'(req_tdata[15:0]);
      b  = signed'(req_tdata[31:16]);
      xa = XY_W'(a) <<< 8;
      yb = XY_W'(b) <<< 8;
      bw = 17'(b);
      if (bw > PI_Q12) begin
         bw = bw - TWO_PI_Q12;
      end else if (bw < -PI_Q12) begin
         bw = bw + TWO_PI_Q12;
      end
      zb = Z_W'(bw) <<< 8;
      stg_in[0].cmd    = cmd_type'(req_tuser);
      stg_in[0].origin = (a == 16'sd0) && (b == 16'sd0);
      if (cmd_type'(req_tuser) == CMD_CART_TO_POL) begin
         stg_in[0].x = xa;
         stg_in[0].y = yb;
         stg_in[0].z = '0;
         if (xa < 0) begin
            if (yb >= 0) begin
               stg_in[0].x = yb;
               stg_in[0].y = -xa;
               stg_in[0].z = HALF_PI_Z;
            end else begin
               stg_in[0].x = -yb;
               stg_in[0].y = xa;
               stg_in[0].z = -HALF_PI_Z;
            end
         end
      end else begin
         stg_in[0].x = xa;
         stg_in[0].y = '0;
         stg_in[0].z = zb;
         if (zb > HALF_PI_Z) begin
            stg_in[0].x = '0;
            stg_in[0].y = xa;
            stg_in[0].z = zb - HALF_PI_Z;
         end else if (zb < -HALF_PI_Z) begin
            stg_in[0].x = '0;
            stg_in[0].y = -xa;
            stg_in[0].z = zb + HALF_PI_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff[0] <= stg_in[0];
      end
   end

   // one register per CORDIC iteration
   for (genvar i = 0; i < N_ITER; i++) begin : g_iter
      always_comb begin
         logic signed [XY_W-1:0] dx;
         logic signed [XY_W-1:0] dy;
         logic signed [Z_W-1:0]  az;
         logic                   add_dir;
         dx = stg_ff[i].y >>> i;
         dy = stg_ff[i].x >>> i;
         az = atan_z(IDX_W'(i));
         add_dir = (stg_ff[i].cmd == CMD_CART_TO_POL) ? (stg_ff[i].y >= 0)
                                                     : (stg_ff[i].z < 0);
         stg_in[i+1].cmd    = stg_ff[i].cmd;
         stg_in[i+1].origin = stg_ff[i].origin;
         if (add_dir) begin
            stg_in[i+1].x = stg_ff[i].x + dx;
            stg_in[i+1].y = stg_ff[i].y - dy;
            stg_in[i+1].z = stg_ff[i].z + az;
         end else begin
            stg_in[i+1].x = stg_ff[i].x - dx;
            stg_in[i+1].y = stg_ff[i].y + dy;
            stg_in[i+1].z = stg_ff[i].z - az;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[i+1] <= stg_in[i+1];
         end
      end
   end

   // gain correction
   assign mul_px_in = stg_ff[N_ITER].x * GAIN_Q16;
   assign mul_py_in = stg_ff[N_ITER].y * GAIN_Q16;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (adv) begin
         mul_vld_ff <= vld_ff[N_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_cmd_ff    <= stg_ff[N_ITER].cmd;
         mul_origin_ff <= stg_ff[N_ITER].origin;
         mul_z_ff      <= stg_ff[N_ITER].z;
         mul_px_ff     <= mul_px_in;
         mul_py_ff     <= mul_py_in;
      end
   end

   // round to nearest, then clamp
   always_comb begin
      logic signed [PROD_W:0]   sx;
      logic signed [PROD_W:0]   sy;
      logic signed [RND_W-1:0]  rx;
      logic signed [RND_W-1:0]  ry;
      logic signed [Z_W:0]      sz;
      logic signed [16:0]       rz;
      sx = (PROD_W+1)'(mul_px_ff) + ((PROD_W+1)'(1) <<< 23);
      sy = (PROD_W+1)'(mul_py_ff) + ((PROD_W+1)'(1) <<< 23);
      rx = signed'(sx[PROD_W:24]);
      ry = signed'(sy[PROD_W:24]);
      sz = (Z_W+1)'(mul_z_ff) + (Z_W+1)'(128);
      rz = signed'(sz[Z_W:8]);
      out_sat_in = 1'b0;
      if (mul_cmd_ff == CMD_CART_TO_POL) begin
         if (rx > RADIUS_MAX) begin
            rx = RADIUS_MAX;
         end else if (rx < 0) begin
            rx = '0;
         end
         if (rz > PI_Q12) begin
            rz = PI_Q12;
         end else if (rz < -PI_Q12) begin
            rz = -PI_Q12;
         end
         out_first_in  = 17'(rx);
         out_second_in = 16'(rz);
         if (mul_origin_ff) begin
            out_first_in  = '0;
            out_second_in = '0;
         end
      end else begin
         if (rx > CLIP_HI) begin
            rx = CLIP_HI;
            out_sat_in = 1'b1;
         end else if (rx < CLIP_LO) begin
            rx = CLIP_LO;
            out_sat_in = 1'b1;
         end
         if (ry > CLIP_HI) begin
            ry = CLIP_HI;
            out_sat_in = 1'b1;
         end else if (ry < CLIP_LO) begin
            ry = CLIP_LO;
            out_sat_in = 1'b1;
         end
         out_first_in  = 17'(rx);
         out_second_in = 16'(ry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_cmd_ff    <= mul_cmd_ff;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_sat_ff    <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'b0, out_second_ff, out_first_ff};
   assign rsp_tuser  = out_sat_ff;

   `CHK_IMPLY(a_polar_no_sat, clock, reset,
      out_vld_ff && (out_cmd_ff == CMD_CART_TO_POL), !out_sat_ff,
      "saturated flag set on a cartesian-to-polar result")
   `CHK_IMPLY(a_angle_range, clock, reset,
      out_vld_ff && (out_cmd_ff == CMD_CART_TO_POL),
      (out_second_ff <= 16'sd12868) && (out_second_ff >= -16'sd12868),
      "angle outside plus/minus pi")
   `CHK_IMPLY(a_radius_range, clock, reset,
      out_vld_ff && (out_cmd_ff == CMD_CART_TO_POL),
      (out_first_ff >= 17'sd0) && (out_first_ff <= 17'sd46341),
      "radius outside its range")
   `CHK_NEXT(a_mul_advance, clock, reset,
      adv && vld_ff[N_ITER], mul_vld_ff,
      "last iteration beat lost on the way to the multiply stage")

endmodule

/* test/polar_cartesian_converter_checker.sv */
// Checker for the polar/cartesian converter: predicts each result and compares on the fly
`timescale 1ns / 1ps

module polar_cartesian_converter_checker
   import pcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] first_value, [31:16] second_value
   input  logic        req_tuser,   // [0] command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [16:0] first_result, [32:17] second_result, zero fill
   input  logic        rsp_tuser,   // [0] saturated
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic signed [16:0] radius_or_x;
      logic signed [15:0] angle_or_y;
      logic               clipped;
   } coord_result_type;

   localparam longint GAIN_K    = 39797;
   localparam longint PI_ANGLE  = 12868;
   localparam longint TWO_PI    = 25736;
   localparam longint QUARTER_Z = 1647099;
   localparam longint RADIUS_LIM = 46341;

   // atan(2^-i) with 20 fraction bits
   localparam longint ATAN_STEP [0:23] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0, 0, 0
   };

   coord_result_type expected_results[$];

   // 16 fraction bits times the gain constant, rounded to Q7.8
   function automatic longint apply_gain(input longint v);
      return (v * GAIN_K + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic coord_result_type convert_pair(input cmd_type cmd,
                                                     input logic signed [15:0] first_value,
                                                     input logic signed [15:0] second_value);
      longint a, b, x, y, z, t, dx, dy, r0, r1, hi, lo;
      logic sat;
      coord_result_type res;
      a = first_value;
      b = second_value;
      sat = 1'b0;
      if (cmd == CMD_CART_TO_POL) begin
         x = a * 256;
         y = b * 256;
         z = 0;
         // fold the left half-plane onto the right one
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = QUARTER_Z;
            end else begin
               t = x; x = -y; y = t; z = -QUARTER_Z;
            end
         end
         for (int i = 0; i < N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += ATAN_STEP[i];
            end else begin
               x -= dx; y += dy; z -= ATAN_STEP[i];
            end
         end
         r0 = apply_gain(x);
         if (r0 > RADIUS_LIM) r0 = RADIUS_LIM;
         if (r0 < 0) r0 = 0;
         r1 = (z + 128) >>> 8;
         if (r1 > PI_ANGLE) r1 = PI_ANGLE;
         if (r1 < -PI_ANGLE) r1 = -PI_ANGLE;
         if (a == 0 && b == 0) begin
            r0 = 0;
            r1 = 0;
         end
      end else begin
         hi = (64'sd1 <<< (CLIP_W - 1)) - 1;
         lo = -(64'sd1 <<< (CLIP_W - 1));
         // wrap an angle beyond plus/minus pi once
         if (b > PI_ANGLE) b -= TWO_PI;
         else if (b < -PI_ANGLE) b += TWO_PI;
         x = a * 256;
         y = 0;
         z = b * 256;
         if (z > QUARTER_Z) begin
            y = x; x = 0; z -= QUARTER_Z;
         end else if (z < -QUARTER_Z) begin
            y = -x; x = 0; z += QUARTER_Z;
         end
         for (int i = 0; i < N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_STEP[i];
            end else begin
               x += dx; y -= dy; z += ATAN_STEP[i];
            end
         end
         r0 = apply_gain(x);
         r1 = apply_gain(y);
         if (r0 > hi) begin r0 = hi; sat = 1'b1; end
         if (r0 < lo) begin r0 = lo; sat = 1'b1; end
         if (r1 > hi) begin r1 = hi; sat = 1'b1; end
         if (r1 < lo) begin r1 = lo; sat = 1'b1; end
      end
      res.radius_or_x = r0[16:0];
      res.angle_or_y  = r1[15:0];
      res.clipped     = sat;
      return res;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      coord_result_type want;
      coord_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.radius_or_x = rsp_tdata[16:0];
            got.angle_or_y  = rsp_tdata[32:17];
            got.clipped     = rsp_tuser;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result beat r0=%0d r1=%0d sat=%0b", $realtime,
                           got.radius_or_x, got.angle_or_y, got.clipped);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch r0 exp %0d got %0d, r1 exp %0d got %0d,",
                               " sat exp %0b got %0b"},
                              $realtime, want.radius_or_x, got.radius_or_x,
                              want.angle_or_y, got.angle_or_y, want.clipped, got.clipped);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(convert_pair(cmd_type'(req_tuser), req_tdata[15:0],
                                                    req_tdata[31:16]));
      end
      pending_count = expected_results.size();
   end

endmodule

/* test/tb_polar_cartesian_converter_unit.sv */
// Testbench top for the polar/cartesian converter: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_polar_cartesian_converter_unit;
   import pcc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] first_value, [31:16] second_value
   logic        req_tuser;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [16:0] first_result, [32:17] second_result, zero fill
   logic        rsp_tuser;   // [0] saturated

   int error_count;
   int pending_count;
   bit idling_on;

   polar_cartesian_converter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   polar_cartesian_converter_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3000000;
      $display("polar_cartesian_converter_unit regression: fail");
      $finish;
   end

   // called at a falling edge; returns at a falling edge after the beat is taken
   task automatic send_pair(input cmd_type cmd, input logic [15:0] first_value,
                            input logic [15:0] second_value);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {second_value, first_value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_random(input int count);
      int angle;
      logic [15:0] fv;
      logic [15:0] sv;
      cmd_type cmd;
      for (int n = 0; n < count; n++) begin
         cmd = cmd_type'($urandom_range(0, 1));
         fv = 16'($urandom());
         sv = 16'($urandom());
         if (cmd == CMD_POL_TO_CART) begin
            // mostly a valid radius and an angle within plus/minus pi
            if ($urandom_range(0, 5) != 0) begin
               angle = int'($urandom_range(0, 25736)) - 12868;
               sv = angle[15:0];
            end
            if ($urandom_range(0, 4) != 0) fv = 16'($urandom_range(0, 32767));
         end else if ($urandom_range(0, 5) == 0) begin
            // small coordinates near the origin
            angle = int'($urandom_range(0, 511)) - 256;
            fv = angle[15:0];
            angle = int'($urandom_range(0, 511)) - 256;
            sv = angle[15:0];
         end
         send_pair(cmd, fv, sv);
      end
   endtask

   // result-side stalls in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      idling_on  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CART_TO_POL;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      idling_on = 1'b1;

      // cartesian to polar: origin, axes and corners
      send_pair(CMD_CART_TO_POL, 16'sd0, 16'sd0);
      send_pair(CMD_CART_TO_POL, -16'sd1, 16'sd0);
      send_pair(CMD_CART_TO_POL, -16'sd32768, 16'sd0);
      send_pair(CMD_CART_TO_POL, 16'sd1, 16'sd0);
      send_pair(CMD_CART_TO_POL, 16'sd0, 16'sd32767);
      send_pair(CMD_CART_TO_POL, 16'sd0, -16'sd32768);
      send_pair(CMD_CART_TO_POL, 16'sd32767, 16'sd32767);
      send_pair(CMD_CART_TO_POL, -16'sd32768, -16'sd32768);
      send_pair(CMD_CART_TO_POL, -16'sd32768, 16'sd32767);
      send_pair(CMD_CART_TO_POL, 16'sd32767, -16'sd32768);
      send_pair(CMD_CART_TO_POL, -16'sd256, -16'sd1);
      // polar to cartesian: angle limits, wrap beyond pi, negative radius, clipping
      send_pair(CMD_POL_TO_CART, 16'sd0, 16'sd3217);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd0);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd3217);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd6434);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd12868);
      send_pair(CMD_POL_TO_CART, 16'sd32767, -16'sd12868);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd12869);
      send_pair(CMD_POL_TO_CART, 16'sd32767, -16'sd12869);
      send_pair(CMD_POL_TO_CART, 16'sd32767, 16'sd32767);
      send_pair(CMD_POL_TO_CART, 16'sd32767, -16'sd32768);
      send_pair(CMD_POL_TO_CART, -16'sd32768, 16'sd0);
      send_pair(CMD_POL_TO_CART, -16'sd32768, 16'sd12868);
      send_pair(CMD_POL_TO_CART, -16'sd32768, -16'sd6434);

      send_random(300);
      idling_on = 1'b0;
      send_random(100);
      idling_on = 1'b1;
      send_random(350);
      // closing stretch at full rate
      idling_on = 1'b0;
      send_random(150);
      req_tvalid = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("polar_cartesian_converter_unit regression: pass");
      else
         $display("polar_cartesian_converter_unit regression: fail");
      $finish;
   end

endmodule
